/* rtl/core/tlec_pkg.sv */
// Package for the two-level exclusive cache lookup unit.
// Sizes, register indexes and the state encoding; no dependencies.
`default_nettype none
package tlec_pkg;
  localparam int L1_SETS = 64;
  localparam int L1_WAYS = 8;
  localparam int L2_SETS = 256;
  localparam int L2_WAYS = 8;
  localparam int ADDR_BITS = 48;
  localparam int OFFSET_BITS = 12;
  localparam int CFG_W = 4;

  localparam logic [2:0] REG_L1_SET_BITS = 3'd0;
  localparam logic [2:0] REG_L1_WAYS     = 3'd1;
  localparam logic [2:0] REG_BLOCK_BITS  = 3'd2;
  localparam logic [2:0] REG_L1_POLICY   = 3'd3;
  localparam logic [2:0] REG_L2_SET_BITS = 3'd4;
  localparam logic [2:0] REG_L2_WAYS     = 3'd5;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FLUSH = 8'b0000_0010,
    ST_L1RD  = 8'b0000_0100,
    ST_L1CMP = 8'b0000_1000,
    ST_L2RD  = 8'b0001_0000,
    ST_L2CMP = 8'b0010_0000,
    ST_VICRD = 8'b0100_0000,
    ST_VICWR = 8'b1000_0000
  } state_t;
endpackage
`default_nettype wire

/* rtl/core/two_level_exclusive_cache_lookup_unit.sv */
// Top level of the two-level exclusive cache lookup unit.
// Uses tlec_pkg for sizes, register indexes and state codes.
//
//  channel   signals                                   direction
//  request   start, busy, access_addr, is_write        in / busy out
//  result    done, l1_hit, l2_hit, mem_read, mem_write, victim_to_l2   out
//  config    cfg_we, cfg_index, cfg_data                in
//
// Each stage reads the valid bits and order of one set, then a shared tag
// comparator scans the ways one per cycle. done follows L1RD and L1CMP on an
// L1 hit; on a miss it follows L1RD, L1CMP, L2RD, L2CMP, VICRD and VICWR, and
// then the push when a valid victim goes into L2 (busy covers that push).
// The next request is taken at the edge that ends the done cycle.
// Reset and every write to one of the six config registers start a flush
// that clears valid bits and order, one set of each level per cycle; busy meanwhile.
// The result strobe done is high one cycle; the receiver cannot stall.
`default_nettype none
module two_level_exclusive_cache_lookup_unit #(
  parameter int L1_SETS     = tlec_pkg::L1_SETS,
  parameter int L1_WAYS     = tlec_pkg::L1_WAYS,
  parameter int L2_SETS     = tlec_pkg::L2_SETS,
  parameter int L2_WAYS     = tlec_pkg::L2_WAYS,
  parameter int ADDR_BITS   = tlec_pkg::ADDR_BITS,
  parameter int OFFSET_BITS = tlec_pkg::OFFSET_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ADDR_BITS-1:0] access_addr,
  input  wire logic                 is_write,
  output logic                      done,
  output logic                      l1_hit,
  output logic                      l2_hit,
  output logic                      mem_read,
  output logic                      mem_write,
  output logic                      victim_to_l2,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [tlec_pkg::CFG_W-1:0] cfg_data
);
  localparam int S1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
  localparam int S2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
  localparam int W1W = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
  localparam int W2W = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
  localparam int I1W = (L1_SETS * L1_WAYS > 1) ? $clog2(L1_SETS * L1_WAYS) : 1;
  localparam int I2W = (L2_SETS * L2_WAYS > 1) ? $clog2(L2_SETS * L2_WAYS) : 1;
  localparam int WMAX = (L1_WAYS > L2_WAYS) ? L1_WAYS : L2_WAYS;
  localparam int WC = $clog2(WMAX + 1);
  localparam int SHW = $clog2(ADDR_BITS + 1) + 1;
  localparam int FW = (L1_SETS > L2_SETS) ? S1W : S2W;
  localparam int MAXS1 = $clog2(L1_SETS);
  localparam int MAXS2 = $clog2(L2_SETS);

  // valid bits and order per set; tag and offset per way, at set*ways+way
  typedef logic [ADDR_BITS-1:0]   tag_t;
  typedef logic [OFFSET_BITS-1:0] off_t;

  // config registers
  logic [2:0] l1_set_bits;
  logic [3:0] l1_ways, block_bits, l2_set_bits, l2_ways;
  logic       l1_policy;

  // memories
  logic [L1_WAYS-1:0]         m1_valid [L1_SETS];
  logic [L1_WAYS*W1W-1:0]     m1_order [L1_SETS];
  tag_t                       m1_tag   [L1_SETS*L1_WAYS];
  off_t                       m1_off   [L1_SETS*L1_WAYS];
  logic [L2_WAYS-1:0]         m2_valid [L2_SETS];
  logic [L2_WAYS*W2W-1:0]     m2_order [L2_SETS];
  tag_t                       m2_tag   [L2_SETS*L2_WAYS];
  off_t                       m2_off   [L2_SETS*L2_WAYS];

  tlec_pkg::state_t state;

  // derived geometry
  logic [SHW-1:0] b, s1, s2;
  logic [WC-1:0]  a1, a2;

  always_comb begin
    b = (32'(block_bits) > OFFSET_BITS) ? SHW'(OFFSET_BITS) : SHW'(block_bits);
    s1 = (SHW'(l1_set_bits) > SHW'(MAXS1)) ? SHW'(MAXS1) : SHW'(l1_set_bits);
    s2 = (SHW'(l2_set_bits) > SHW'(MAXS2)) ? SHW'(MAXS2) : SHW'(l2_set_bits);
    a1 = (l1_ways == 4'd0) ? WC'(1) :
         ((32'(l1_ways) > L1_WAYS) ? WC'(L1_WAYS) : WC'(l1_ways));
    a2 = (l2_ways == 4'd0) ? WC'(1) :
         ((32'(l2_ways) > L2_WAYS) ? WC'(L2_WAYS) : WC'(l2_ways));
  end

  function automatic tag_t lmask(input logic [SHW-1:0] n);
    lmask = (n >= SHW'(ADDR_BITS)) ? '1 : ((tag_t'(1) << n) - tag_t'(1));
  endfunction

  function automatic logic [I1W-1:0] idx1(input logic [S1W-1:0] s, input logic [W1W-1:0] w);
    idx1 = I1W'(32'(s) * L1_WAYS + 32'(w));
  endfunction

  function automatic logic [I2W-1:0] idx2(input logic [S2W-1:0] s, input logic [W2W-1:0] w);
    idx2 = I2W'(32'(s) * L2_WAYS + 32'(w));
  endfunction

  // request registers
  tag_t          addr;
  logic          wr;
  logic [S1W-1:0] set1;
  tag_t          tag1;
  logic [S2W-1:0] set2;
  tag_t          tag2;
  logic [WC-1:0]  scan;
  logic          hit1, hit2;
  logic [W1W-1:0] hway1;

  // set rows held during the request
  logic [L1_WAYS-1:0]     r1_valid;
  logic [L1_WAYS*W1W-1:0] r1_order;
  logic [L2_WAYS-1:0]     r2_valid;
  logic [L2_WAYS*W2W-1:0] r2_order;
  tag_t rd_tag;
  off_t rd_off;
  logic [W1W-1:0] vway;
  logic [S2W-1:0] vset;
  tag_t          vtag;
  off_t          voff;
  logic          vvalid;
  logic [FW-1:0] fcnt;
  // L2 row of the victim's set, read the cycle before the push
  logic [L2_WAYS-1:0]     v2_valid;
  logic [L2_WAYS*W2W-1:0] v2_order;

  logic pend, push, l1_match;
  logic [W2W-1:0] wvic;
  logic [W2W-1:0] f2;
  assign f2 = v2_order[W2W-1:0];
  assign wvic = (32'(f2) < L2_WAYS) ? f2 : '0;
  assign push = (state == tlec_pkg::ST_IDLE) && pend;

  // split of the request address
  logic [SHW-1:0] sb1, sb2;
  tag_t sa1, sa2, ta1, ta2;
  always_comb begin
    sb1 = s1 + b;
    sb2 = s2 + b;
    sa1 = (access_addr >> b) & lmask(s1);
    sa2 = (access_addr >> b) & lmask(s2);
    ta1 = (sb1 >= SHW'(ADDR_BITS)) ? '0 : (access_addr >> sb1);
    ta2 = (sb2 >= SHW'(ADDR_BITS)) ? '0 : (access_addr >> sb2);
  end

  // victim address rebuilt and re-split for L2
  tag_t old_addr, ov_set, ov_tag;
  always_comb begin
    old_addr = ((sb1 >= SHW'(ADDR_BITS)) ? '0 : (rd_tag << sb1)) |
               (tag_t'(set1) << b) | tag_t'(rd_off);
    ov_set = (old_addr >> b) & lmask(s2);
    ov_tag = (sb2 >= SHW'(ADDR_BITS)) ? '0 : (old_addr >> sb2);
  end

  // order helpers
  function automatic logic [L1_WAYS*W1W-1:0] o1_back(
      input logic [L1_WAYS*W1W-1:0] o, input logic [WC-1:0] n,
      input logic [W1W-1:0] way);
    logic [L1_WAYS*W1W-1:0] r;
    logic found;
    r = o;
    found = 1'b0;
    for (int k = 0; k < L1_WAYS; k++) begin
      if (WC'(k) < n) begin
        if (o[k*W1W +: W1W] == way) found = 1'b1;
        if (found && (WC'(k + 1) < n)) r[k*W1W +: W1W] = o[(k+1)*W1W +: W1W];
      end
    end
    if (found) r[(32'(n) - 1)*W1W +: W1W] = way;
    o1_back = r;
  endfunction

  function automatic logic [L2_WAYS*W2W-1:0] o2_back(
      input logic [L2_WAYS*W2W-1:0] o, input logic [WC-1:0] n);
    logic [L2_WAYS*W2W-1:0] r;
    r = o;
    for (int k = 0; k < L2_WAYS; k++)
      if (WC'(k + 1) < n) r[k*W2W +: W2W] = o[(k+1)*W2W +: W2W];
    r[(32'(n) - 1)*W2W +: W2W] = o[W2W-1:0];
    o2_back = r;
  endfunction

  function automatic logic [L2_WAYS*W2W-1:0] o2_front(
      input logic [L2_WAYS*W2W-1:0] o, input logic [WC-1:0] n,
      input logic [W2W-1:0] way);
    logic [L2_WAYS*W2W-1:0] r;
    logic found;
    logic [WC-1:0] p;
    found = 1'b0;
    p = '0;
    r = o;
    for (int k = 0; k < L2_WAYS; k++)
      if (!found && WC'(k) < n && o[k*W2W +: W2W] == way) begin
        found = 1'b1;
        p = WC'(k);
      end
    if (!found) p = '0;
    for (int k = L2_WAYS - 1; k > 0; k--)
      if (WC'(k) <= p) r[k*W2W +: W2W] = o[(k-1)*W2W +: W2W];
    r[W2W-1:0] = o[32'(p)*W2W +: W2W];
    o2_front = r;
  endfunction

  function automatic logic [L1_WAYS*W1W-1:0] o1_init();
    for (int k = 0; k < L1_WAYS; k++) o1_init[k*W1W +: W1W] = W1W'(k);
  endfunction
  function automatic logic [L2_WAYS*W2W-1:0] o2_init();
    for (int k = 0; k < L2_WAYS; k++) o2_init[k*W2W +: W2W] = W2W'(k);
  endfunction

  // busy must cover the victim push cycle
  assign busy = (state != tlec_pkg::ST_IDLE) || pend;

  logic [W1W-1:0] fv1;
  assign fv1 = r1_order[W1W-1:0];

  assign l1_match = r1_valid[W1W'(scan)] && (rd_tag == tag1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlec_pkg::ST_FLUSH;
      fcnt <= '0;
      l1_set_bits <= 3'd0;
      l1_ways <= 4'd1;
      block_bits <= 4'd6;
      l1_policy <= 1'b0;
      l2_set_bits <= 4'd0;
      l2_ways <= 4'd1;
    end else if (cfg_we && cfg_index <= tlec_pkg::REG_L2_WAYS) begin
      case (cfg_index)
        tlec_pkg::REG_L1_SET_BITS: l1_set_bits <= cfg_data[2:0];
        tlec_pkg::REG_L1_WAYS:     l1_ways <= cfg_data;
        tlec_pkg::REG_BLOCK_BITS:  block_bits <= cfg_data;
        tlec_pkg::REG_L1_POLICY:   l1_policy <= cfg_data[0];
        tlec_pkg::REG_L2_SET_BITS: l2_set_bits <= cfg_data;
        default:                   l2_ways <= cfg_data;
      endcase
      state <= tlec_pkg::ST_FLUSH;
      fcnt <= '0;
    end else begin
      case (state)
        tlec_pkg::ST_IDLE: begin
          if (start && !pend) begin
            addr <= access_addr;
            wr <= is_write;
            set1 <= S1W'(sa1);
            tag1 <= ta1;
            set2 <= S2W'(sa2);
            tag2 <= ta2;
            state <= tlec_pkg::ST_L1RD;
          end
        end
        tlec_pkg::ST_FLUSH: begin
          if (32'(fcnt) < L1_SETS) begin
            m1_valid[S1W'(fcnt)] <= '0;
            m1_order[S1W'(fcnt)] <= o1_init();
          end
          if (32'(fcnt) < L2_SETS) begin
            m2_valid[S2W'(fcnt)] <= '0;
            m2_order[S2W'(fcnt)] <= o2_init();
          end
          if (32'(fcnt) >= L1_SETS - 1 && 32'(fcnt) >= L2_SETS - 1)
            state <= tlec_pkg::ST_IDLE;
          else
            fcnt <= fcnt + FW'(1);
        end
        tlec_pkg::ST_L1RD: begin
          r1_valid <= m1_valid[set1];
          r1_order <= m1_order[set1];
          scan <= '0;
          hit1 <= 1'b0;
          hit2 <= 1'b0;
          vvalid <= 1'b0;
          rd_tag <= m1_tag[idx1(set1, '0)];
          state <= tlec_pkg::ST_L1CMP;
        end
        tlec_pkg::ST_L1CMP: begin
          // one way per cycle through the shared comparator
          if (l1_match) begin
            hit1 <= 1'b1;
            if (l1_policy)
              m1_order[set1] <= o1_back(r1_order, a1, W1W'(scan));
            state <= tlec_pkg::ST_IDLE;
          end else if (scan + WC'(1) >= a1) begin
            state <= tlec_pkg::ST_L2RD;
          end else begin
            rd_tag <= m1_tag[idx1(set1, W1W'(scan + WC'(1)))];
            scan <= scan + WC'(1);
          end
        end
        tlec_pkg::ST_L2RD: begin
          r2_valid <= m2_valid[set2];
          r2_order <= m2_order[set2];
          scan <= '0;
          rd_tag <= m2_tag[idx2(set2, '0)];
          state <= tlec_pkg::ST_L2CMP;
        end
        tlec_pkg::ST_L2CMP: begin
          if (r2_valid[W2W'(scan)] && rd_tag == tag2) begin
            hit2 <= 1'b1;
            r2_valid[W2W'(scan)] <= 1'b0;
            r2_order <= o2_front(r2_order, a2, W2W'(scan));
            state <= tlec_pkg::ST_VICRD;
          end else if (scan + WC'(1) >= a2) begin
            state <= tlec_pkg::ST_VICRD;
          end else begin
            rd_tag <= m2_tag[idx2(set2, W2W'(scan + WC'(1)))];
            scan <= scan + WC'(1);
          end
          vway <= (32'(fv1) < L1_WAYS) ? fv1 : '0;
        end
        tlec_pkg::ST_VICRD: begin
          // write back L2 set changes, fetch the L1 victim line
          m2_valid[set2] <= r2_valid;
          m2_order[set2] <= r2_order;
          m1_order[set1] <= o1_back(r1_order, a1, fv1);
          rd_tag <= m1_tag[idx1(set1, vway)];
          rd_off <= m1_off[idx1(set1, vway)];
          vvalid <= r1_valid[vway];
          hway1 <= vway;
          state <= tlec_pkg::ST_VICWR;
        end
        default: begin
          m1_valid[set1] <= r1_valid | (L1_WAYS'(1) << hway1);
          m1_tag[idx1(set1, hway1)] <= tag1;
          m1_off[idx1(set1, hway1)] <= off_t'(addr & lmask(b));
          v2_valid <= m2_valid[S2W'(ov_set)];
          v2_order <= m2_order[S2W'(ov_set)];
          if (vvalid) begin
            vset <= S2W'(ov_set);
            vtag <= ov_tag;
            voff <= off_t'(old_addr & lmask(b));
          end
          state <= tlec_pkg::ST_IDLE;
        end
      endcase
    end
    // victim push into L2, done once its set row is rewritten
    if (!rst && push) begin
      m2_valid[vset] <= v2_valid | (L2_WAYS'(1) << wvic);
      m2_order[vset] <= o2_back(v2_order, a2);
      m2_tag[idx2(vset, wvic)] <= vtag;
      m2_off[idx2(vset, wvic)] <= voff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= push || (!cfg_we && ((state == tlec_pkg::ST_L1CMP && l1_match) ||
                                   (state == tlec_pkg::ST_VICWR && !vvalid)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (state == tlec_pkg::ST_VICWR && vvalid && !cfg_we) begin
      pend <= 1'b1;
    end else begin
      pend <= 1'b0;
    end
  end

  assign l1_hit = hit1;
  assign l2_hit = !hit1 && hit2;
  assign mem_read = !hit1 && !hit2;
  assign mem_write = wr;
  assign victim_to_l2 = !hit1 && vvalid;

  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe repeated");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot({l1_hit, l2_hit, mem_read})) else $error("flags not exclusive");
  a_hit_novic: assert property (@(posedge clk) disable iff (rst)
    done && l1_hit |-> !victim_to_l2) else $error("victim on L1 hit");
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend |=> done) else $error("victim push without result");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    pend |-> busy) else $error("start during push");
endmodule
`default_nettype wire
